>>> hdl/gyi_pkg.sv
// Shared widths, reset values, register indexes and the request/response
// structs that pass between the core and its serial divider and serial MAC.
// No dependencies.
package gyi_pkg;

  localparam int RAW_W      = 16;
  localparam int TIME_W     = 32;
  localparam int ANGLE_W    = 33;
  localparam int HEAD_W     = 34;
  localparam int BIAS_W     = 25;
  localparam int SUM_W      = 33;
  localparam int CNT_W      = 16;
  localparam int DB_W       = 23;
  localparam int DT_W       = 10;
  localparam int HT_W       = 32;
  localparam int RATE_W     = 26;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  // dividend is |sum| scaled by 2^8; the quotient never exceeds 2^23
  localparam int NUM_W      = SUM_W - 1 + FRAC_W;
  localparam int QUO_W      = BIAS_W - 1;
  localparam int ACC_W      = 37;

  localparam logic [CNT_W-1:0] CALIB_SAMPLES_RST = CNT_W'(100);
  localparam logic [DB_W-1:0]  DEADBAND_RST      = DB_W'(1677);
  localparam logic [DT_W-1:0]  MAX_DT_MS_RST     = DT_W'(100);
  localparam logic [HT_W-1:0]  HALF_TURN_RST     = HT_W'(64'd3018240000);

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DT_MS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_TURN     = 2'd3;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [CNT_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [QUO_W-1:0]   quo;
  } div_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [HEAD_W-1:0] heading;
    logic signed [RATE_W-1:0] rate;
    logic [DT_W-1:0]          dt;
    logic [HT_W-1:0]          half_turn;
  } mac_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [HEAD_W-1:0] heading;
  } mac_rsp_t;

endpackage

>>> hdl/gyi_ifs.sv
// Valid/ready channel interfaces: gyro sample input, heading result output,
// configuration write. Depends on gyi_pkg.
interface gyi_in_if import gyi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic                    sample_ok;
  logic signed [RAW_W-1:0] gyro_raw;
  logic [TIME_W-1:0]       time_ms;

  modport source (output valid, command, sample_ok, gyro_raw, time_ms, input ready);
  modport sink   (input valid, command, sample_ok, gyro_raw, time_ms, output ready);
endinterface

interface gyi_out_if import gyi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  logic                      calibrating;
  logic                      calib_failed;

  modport source (output valid, angle, calibrating, calib_failed, input ready);
  modport sink   (input valid, angle, calibrating, calib_failed, output ready);
endinterface

interface gyi_cfg_if import gyi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/gyro_yaw_integrator_core.sv
// Z-gyro heading integrator with bias calibration, top level.
// An integration step runs the gyi_mac shift-add, a calibration that sets a
// new bias runs the serial divider, and every other word goes straight to the
// output. One word in flight: no new word is taken until its result is issued.
// rst_ni clears control, algorithm and configuration state, not the payload
// registers, and starts automatic bias collection with default register values.
module gyro_yaw_integrator_core import gyi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  gyi_in_if.sink    sample_in,
  gyi_out_if.source result_out,
  gyi_cfg_if.sink   cfg_wr
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] PH_AUTO = 2'd0;
  localparam logic [1:0] PH_REQ  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  localparam logic [1:0] JOB_NONE = 2'd0;
  localparam logic [1:0] JOB_DIV  = 2'd1;
  localparam logic [1:0] JOB_MAC  = 2'd2;

  // configuration
  logic [CNT_W-1:0] calib_samples_q;
  logic [DB_W-1:0]  deadband_q;
  logic [DT_W-1:0]  max_dt_q;
  logic [HT_W-1:0]  half_turn_q;

  // control and algorithm state
  logic [2:0]               state_q, state_d;
  logic [1:0]               job_q, job_d;
  logic [1:0]               phase_q, phase_d;
  logic                     stamp_known_q, stamp_known_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [HEAD_W-1:0] heading_q, heading_d;
  logic [TIME_W-1:0]        last_stamp_q, last_stamp_d;
  logic signed [BIAS_W-1:0] bias_q, bias_d;
  logic signed [SUM_W-1:0]  rate_sum_q, rate_sum_d;
  logic [CNT_W-1:0]         seen_q, seen_d;
  logic [CNT_W-1:0]         good_q, good_d;

  // payload
  logic [TIME_W-1:0]         dt_raw_q, dt_raw_d;
  logic signed [RATE_W-1:0]  rate_q, rate_d;
  logic signed [ANGLE_W-1:0] angle_q, angle_d;
  logic                      cal_q, cal_d;
  logic                      fail_q, fail_d;

  logic                     in_fire;
  logic [CNT_W-1:0]         limit;
  logic [CNT_W:0]           good_inc, seen_inc, good_new;
  logic signed [SUM_W-1:0]  sum_add;
  logic signed [RATE_W-1:0] raw_q8;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [BIAS_W-1:0]        quo_ext;
  logic [RATE_W-1:0]        rate_mag;
  logic signed [RATE_W-1:0] rate_eff;
  logic [DT_W-1:0]          dt_eff;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  assign sample_in.ready = (state_q == S_IDLE);
  assign in_fire         = sample_in.valid && sample_in.ready;
  assign cfg_wr.ready    = 1'b1;

  assign limit    = (calib_samples_q == '0) ? CNT_W'(1) : calib_samples_q;
  assign good_inc = {1'b0, good_q} + (CNT_W+1)'(1);
  assign seen_inc = {1'b0, seen_q} + (CNT_W+1)'(1);
  assign sum_add  = rate_sum_q
                  + {{(SUM_W-RAW_W){sample_in.gyro_raw[RAW_W-1]}}, sample_in.gyro_raw};
  assign raw_q8   = {{(RATE_W-RAW_W-FRAC_W){sample_in.gyro_raw[RAW_W-1]}},
                     sample_in.gyro_raw, {FRAC_W{1'b0}}};

  assign sum_neg  = rate_sum_q[SUM_W-1];
  assign sum_mag  = sum_neg ? -rate_sum_q : rate_sum_q;
  assign quo_ext  = {1'b0, div_rsp.quo};

  assign rate_mag = rate_q[RATE_W-1] ? -rate_q : rate_q;
  assign rate_eff = (rate_mag < RATE_W'(deadband_q)) ? '0 : rate_q;
  assign dt_eff   = (dt_raw_q > TIME_W'(max_dt_q)) ? max_dt_q : dt_raw_q[DT_W-1:0];

  always_comb begin
    state_d       = state_q;
    job_d         = job_q;
    phase_d       = phase_q;
    stamp_known_d = stamp_known_q;
    out_valid_d   = out_valid_q;
    heading_d     = heading_q;
    last_stamp_d  = last_stamp_q;
    bias_d        = bias_q;
    rate_sum_d    = rate_sum_q;
    seen_d        = seen_q;
    good_d        = good_q;
    dt_raw_d      = dt_raw_q;
    rate_d        = rate_q;
    angle_d       = angle_q;
    cal_d         = cal_q;
    fail_d        = fail_q;
    good_new      = {1'b0, good_q};

    div_req.start = 1'b0;
    div_req.num   = {sum_mag[SUM_W-2:0], {FRAC_W{1'b0}}} + NUM_W'(good_q >> 1);
    div_req.den   = good_q;

    mac_req.start     = 1'b0;
    mac_req.heading   = heading_q;
    mac_req.rate      = rate_eff;
    mac_req.dt        = dt_eff;
    mac_req.half_turn = half_turn_q;

    if (out_valid_q && result_out.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          job_d   = JOB_NONE;
          state_d = S_PREP;
          if (sample_in.command) begin
            phase_d    = PH_REQ;
            rate_sum_d = '0;
            seen_d     = '0;
            good_d     = '0;
          end else begin
            case (phase_q)
              PH_AUTO: begin
                if (sample_in.sample_ok) begin
                  last_stamp_d = sample_in.time_ms;
                  if (!stamp_known_q) begin
                    stamp_known_d = 1'b1;
                  end else begin
                    rate_sum_d = sum_add;
                    good_d     = good_inc[CNT_W-1:0];
                    if (good_inc >= {1'b0, limit}) begin
                      job_d = JOB_DIV;
                    end
                  end
                end
              end
              PH_REQ: begin
                seen_d = seen_inc[CNT_W-1:0];
                if (sample_in.sample_ok) begin
                  rate_sum_d = sum_add;
                  good_d     = good_inc[CNT_W-1:0];
                  good_new   = good_inc;
                end
                if (seen_inc >= {1'b0, limit}) begin
                  if (good_new == '0) begin
                    phase_d = PH_FAIL;
                  end else begin
                    last_stamp_d  = sample_in.time_ms;
                    stamp_known_d = 1'b1;
                    job_d         = JOB_DIV;
                  end
                end
              end
              default: begin
                if (sample_in.sample_ok) begin
                  last_stamp_d = sample_in.time_ms;
                  if (!stamp_known_q) begin
                    stamp_known_d = 1'b1;
                  end else begin
                    dt_raw_d = sample_in.time_ms - last_stamp_q;
                    rate_d   = raw_q8 - {bias_q[BIAS_W-1], bias_q};
                    job_d    = JOB_MAC;
                  end
                end
              end
            endcase
          end
        end
      end
      S_PREP: begin
        case (job_q)
          JOB_DIV: begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
          JOB_MAC: begin
            mac_req.start = 1'b1;
            state_d       = S_MAC;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          bias_d    = sum_neg ? -$signed(quo_ext) : $signed(quo_ext);
          heading_d = '0;
          phase_d   = PH_RUN;
          state_d   = S_OUT;
        end
      end
      S_MAC: begin
        if (mac_rsp.done) begin
          heading_d = mac_rsp.heading;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || result_out.ready) begin
          out_valid_d = 1'b1;
          cal_d       = (phase_q == PH_AUTO) || (phase_q == PH_REQ);
          fail_d      = (phase_q == PH_FAIL);
          angle_d     = cal_d ? '0 : heading_q[ANGLE_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      job_q         <= JOB_NONE;
      phase_q       <= PH_AUTO;
      stamp_known_q <= 1'b0;
      out_valid_q   <= 1'b0;
      heading_q     <= '0;
      last_stamp_q  <= '0;
      bias_q        <= '0;
      rate_sum_q    <= '0;
      seen_q        <= '0;
      good_q        <= '0;
    end else begin
      state_q       <= state_d;
      job_q         <= job_d;
      phase_q       <= phase_d;
      stamp_known_q <= stamp_known_d;
      out_valid_q   <= out_valid_d;
      heading_q     <= heading_d;
      last_stamp_q  <= last_stamp_d;
      bias_q        <= bias_d;
      rate_sum_q    <= rate_sum_d;
      seen_q        <= seen_d;
      good_q        <= good_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_samples_q <= CALIB_SAMPLES_RST;
      deadband_q      <= DEADBAND_RST;
      max_dt_q        <= MAX_DT_MS_RST;
      half_turn_q     <= HALF_TURN_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_CALIB_SAMPLES: calib_samples_q <= cfg_wr.data[CNT_W-1:0];
        REG_DEADBAND:      deadband_q      <= cfg_wr.data[DB_W-1:0];
        REG_MAX_DT_MS:     max_dt_q        <= cfg_wr.data[DT_W-1:0];
        REG_HALF_TURN:     half_turn_q     <= cfg_wr.data[HT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    dt_raw_q <= dt_raw_d;
    rate_q   <= rate_d;
    angle_q  <= angle_d;
    cal_q    <= cal_d;
    fail_q   <= fail_d;
  end

  gyi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gyi_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  assign result_out.valid        = out_valid_q;
  assign result_out.angle        = angle_q;
  assign result_out.calibrating  = cal_q;
  assign result_out.calib_failed = fail_q;

endmodule

>>> hdl/gyi_div.sv
// Restoring divider, one quotient bit per cycle, for the bias mean.
// Depends on gyi_pkg.
module gyi_div import gyi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  nq_q, nq_d;   // dividend shifts out, quotient shifts in
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W+1:0]  diff;

  always_comb begin
    rem_sh = {rem_q[CNT_W-1:0], nq_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      nq_d   = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      nq_d   = {nq_q[NUM_W-2:0], ~diff[CNT_W+1]};
      rem_d  = diff[CNT_W+1] ? rem_sh : diff[CNT_W:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q[QUO_W-1:0];

endmodule

>>> hdl/gyi_mac.sv
// Serial heading update: shift-add of rate times dt, one dt bit per cycle,
// then a single wrap step and a saturation step. Depends on gyi_pkg.
module gyi_mac import gyi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  localparam int CNT_BITS = $clog2(DT_W);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_WRAP = 2'd2;
  localparam logic [1:0] M_SAT  = 2'd3;

  logic [1:0]               stage_q, stage_d;
  logic                     done_q, done_d;
  logic [CNT_BITS-1:0]      cnt_q, cnt_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  m_q, m_d;
  logic [DT_W-1:0]          dt_q, dt_d;
  logic [HT_W-1:0]          ht_q, ht_d;
  logic signed [ACC_W-1:0]  ht_pos, ht_neg, ht_two;

  always_comb begin
    ht_pos  = $signed({{(ACC_W-HT_W){1'b0}}, ht_q});
    ht_neg  = -ht_pos;
    ht_two  = ht_pos <<< 1;
    stage_d = stage_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    m_d     = m_q;
    dt_d    = dt_q;
    ht_d    = ht_q;
    case (stage_q)
      M_IDLE: begin
        if (req_i.start) begin
          acc_d   = {{(ACC_W-HEAD_W){req_i.heading[HEAD_W-1]}}, req_i.heading};
          m_d     = {{(ACC_W-RATE_W){req_i.rate[RATE_W-1]}}, req_i.rate};
          dt_d    = req_i.dt;
          ht_d    = req_i.half_turn;
          cnt_d   = '0;
          stage_d = M_MUL;
        end
      end
      M_MUL: begin
        if (dt_q[0]) begin
          acc_d = acc_q + m_q;
        end
        m_d   = m_q <<< 1;
        dt_d  = dt_q >> 1;
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(DT_W - 1)) begin
          stage_d = M_WRAP;
        end
      end
      M_WRAP: begin
        if (acc_q > ht_pos) begin
          acc_d = acc_q - ht_two;
        end else if (acc_q < ht_neg) begin
          acc_d = acc_q + ht_two;
        end
        stage_d = M_SAT;
      end
      M_SAT: begin
        if (acc_q > ht_pos) begin
          acc_d = ht_pos;
        end else if (acc_q < ht_neg) begin
          acc_d = ht_neg;
        end
        done_d  = 1'b1;
        stage_d = M_IDLE;
      end
      default: begin
        stage_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= M_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      stage_q <= stage_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    m_q   <= m_d;
    dt_q  <= dt_d;
    ht_q  <= ht_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.heading = acc_q[HEAD_W-1:0];

endmodule
